### sv/sitm_pkg.sv
package sitm_pkg;

    localparam int FIELD_W = 32;
    localparam int COUNT_W = 7;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_MERGE  = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [FIELD_W-1:0] pos_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic [1:0] action;
        pos_t       range_first;
        pos_t       range_last;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        count_t     entry_count;
        pos_t       out_first;
        pos_t       out_last;
        logic       final_item;
    } rsp_t;

    // read address select
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_PTR_M1,
        RD_PTR_M2,
        RD_PTR_P1
    } rd_sel_t;

    typedef struct packed {
        logic       cap_key;
        logic       ptr_load_count;
        logic       ptr_clear;
        logic       ptr_inc;
        logic       shift;
        logic       put_key;
        logic       run_load;
        logic       run_walk;
        logic       run_close;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       emit;
        logic       emit_entry;
        logic [1:0] emit_status;
        logic       emit_final;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic ptr_zero;
        logic ptr_one;
        logic ptr_last;
        logic entry_gt;
        logic out_free;
    } stat_t;

endpackage

### sv/sitm_ram.sv
module sitm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/sitm_dp.sv
module sitm_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int POS_WIDTH   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sitm_pkg::req_t   req,
    input  sitm_pkg::cmd_t   cmd,
    output sitm_pkg::stat_t  stat,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output sitm_pkg::rsp_t   rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 2 * POS_WIDTH;

    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        run_idx_reg, run_idx_next;
    logic [EW-1:0]        key_reg, key_next;
    logic [POS_WIDTH-1:0] run_first_reg, run_first_next;
    logic [POS_WIDTH-1:0] run_last_reg, run_last_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    sitm_pkg::rsp_t       rsp_reg, rsp_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [AW-1:0]        rd_addr;
    logic [EW-1:0]        rd_data;
    logic [POS_WIDTH-1:0] rd_first, rd_last;
    logic                 overlap;

    sitm_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_first = rd_data[EW-1:POS_WIDTH];
    assign rd_last  = rd_data[POS_WIDTH-1:0];
    // shared endpoints count as overlap
    assign overlap  = !((rd_last < run_first_reg) || (rd_first > run_last_reg));

    always_comb
    begin
        unique case (cmd.rd_sel)
            sitm_pkg::RD_ZERO:   rd_addr = '0;
            sitm_pkg::RD_PTR_M1: rd_addr = ptr_reg - AW'(1);
            sitm_pkg::RD_PTR_M2: rd_addr = ptr_reg - AW'(2);
            sitm_pkg::RD_PTR_P1: rd_addr = ptr_reg + AW'(1);
            default:             rd_addr = ptr_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = key_reg;
        if (cmd.shift)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data;
        end
        else if (cmd.put_key)
        begin
            wr_en = 1'b1;
        end
        else if ((cmd.run_walk && !overlap) || cmd.run_close)
        begin
            wr_en   = 1'b1;
            wr_addr = run_idx_reg;
            wr_data = {run_first_reg, run_last_reg};
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        run_idx_next   = run_idx_reg;
        key_next       = key_reg;
        run_first_next = run_first_reg;
        run_last_next  = run_last_reg;

        if (cmd.cap_key)
        begin
            key_next = {req.range_first[POS_WIDTH-1:0], req.range_last[POS_WIDTH-1:0]};
        end
        if (cmd.ptr_load_count)
        begin
            ptr_next = count_reg[AW-1:0];
        end
        if (cmd.ptr_clear)
        begin
            ptr_next = '0;
        end
        if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
        if (cmd.shift)
        begin
            ptr_next = ptr_reg - AW'(1);
        end
        if (cmd.put_key)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.run_load)
        begin
            run_first_next = rd_first;
            run_last_next  = rd_last;
            run_idx_next   = '0;
        end
        if (cmd.run_walk)
        begin
            if (overlap)
            begin
                // extend the run's end to the larger one
                if (rd_last > run_last_reg)
                begin
                    run_last_next = rd_last;
                end
            end
            else
            begin
                run_idx_next   = run_idx_reg + AW'(1);
                run_first_next = rd_first;
                run_last_next  = rd_last;
            end
        end
        if (cmd.run_close)
        begin
            count_next = CW'(run_idx_reg) + CW'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (cmd.emit)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = cmd.emit_status;
            rsp_next.entry_count = sitm_pkg::count_t'(count_reg);
            rsp_next.final_item  = cmd.emit_final;
            if (cmd.emit_entry)
            begin
                rsp_next.out_first = sitm_pkg::pos_t'(rd_first);
                rsp_next.out_last  = sitm_pkg::pos_t'(rd_last);
            end
            else
            begin
                rsp_next.out_first = '0;
                rsp_next.out_last  = '0;
            end
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        run_idx_reg   <= run_idx_next;
        key_reg       <= key_next;
        run_first_reg <= run_first_next;
        run_last_reg  <= run_last_next;
        rsp_reg       <= rsp_next;
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(TABLE_DEPTH));
    assign stat.ptr_zero   = (ptr_reg == '0);
    assign stat.ptr_one    = (ptr_reg == AW'(1));
    assign stat.ptr_last   = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign stat.entry_gt   = (rd_data > key_reg);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("stored count beyond table depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp_valid_reg || rsp_ready))
        else $error("result register overwritten while pending");

    a_run_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_walk |-> (run_idx_reg < ptr_reg))
        else $error("merge run index caught up with read pointer");

endmodule

### sv/sitm_ctrl.sv
module sitm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [1:0]       action,
    input  sitm_pkg::stat_t  stat,
    output sitm_pkg::cmd_t   cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INS_CHK  = 9'b000000010,
        S_INS_CMP  = 9'b000000100,
        S_INS_PUT  = 9'b000001000,
        S_MRG_LD   = 9'b000010000,
        S_MRG_WALK = 9'b000100000,
        S_MRG_END  = 9'b001000000,
        S_DMP_OUT  = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.rd_sel = sitm_pkg::RD_ZERO;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (req_valid)
                begin
                    code_next = sitm_pkg::ST_OK;
                    case (action)
                        sitm_pkg::ACT_INSERT:
                        begin
                            cmd.cap_key        = 1'b1;
                            cmd.ptr_load_count = 1'b1;
                            if (stat.full)
                            begin
                                code_next  = sitm_pkg::ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_INS_CHK;
                            end
                        end
                        sitm_pkg::ACT_MERGE:
                        begin
                            if (stat.count_zero)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cmd.ptr_clear = 1'b1;
                                cmd.rd_en     = 1'b1;
                                state_next    = S_MRG_LD;
                            end
                        end
                        sitm_pkg::ACT_DUMP:
                        begin
                            if (stat.count_zero)
                            begin
                                code_next  = sitm_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cmd.ptr_clear = 1'b1;
                                cmd.rd_en     = 1'b1;
                                state_next    = S_DMP_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_CHK:
            begin
                if (stat.ptr_zero)
                begin
                    cmd.put_key = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sitm_pkg::RD_PTR_M1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (stat.entry_gt)
                begin
                    cmd.shift = 1'b1;
                    if (stat.ptr_one)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sitm_pkg::RD_PTR_M2;
                    end
                end
                else
                begin
                    cmd.put_key = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_INS_PUT:
            begin
                cmd.put_key = 1'b1;
                state_next  = S_RESP;
            end
            S_MRG_LD, S_MRG_WALK:
            begin
                cmd.run_load = (state_reg == S_MRG_LD);
                cmd.run_walk = (state_reg == S_MRG_WALK);
                if (stat.ptr_last)
                begin
                    state_next = S_MRG_END;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = sitm_pkg::RD_PTR_P1;
                    state_next  = S_MRG_WALK;
                end
            end
            S_MRG_END:
            begin
                cmd.run_close = 1'b1;
                state_next    = S_RESP;
            end
            S_DMP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_entry  = 1'b1;
                    cmd.emit_status = sitm_pkg::ST_OK;
                    cmd.emit_final  = stat.ptr_last;
                    if (stat.ptr_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = sitm_pkg::RD_PTR_P1;
                    end
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = code_reg;
                    cmd.emit_final  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= sitm_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

### sv/sorted_interval_table_merge.sv
// Sorted table of closed ranges [first, last], ordered by first, then last.
// Request channel (req_valid / req_ready / req) carries one item per
// operation: insert a range, merge overlapping ranges, or dump the table.
// Response channel (rsp_valid / rsp_ready / rsp) returns one item per
// insert, merge or unknown action, and one item per stored range on a dump
// (a single status item if the table is empty); final_item marks the last
// response item of a request.
// With N ranges stored, insert shifts every entry greater than the new
// range up one place, merge walks all N entries of a non-empty table, and
// dump reads the first range and then streams one range per cycle while
// the receiver takes them. The range memory has a single read port.
// A request is taken only while the controller is idle; it is taken even
// while the previous response still sits in the output register.
// If the receiver stalls, the output register holds its item and the
// controller waits before producing the next one; nothing is lost.
// Reset empties the table at once (count cleared, no memory sweep) and
// drops any pending response.
module sorted_interval_table_merge #(
    parameter int TABLE_DEPTH = 64,
    parameter int POS_WIDTH   = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sitm_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output sitm_pkg::rsp_t  rsp
);

    sitm_pkg::cmd_t  cmd;
    sitm_pkg::stat_t stat;

    // sequencing: one operation at a time
    sitm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .action    (req.action),
        .stat      (stat),
        .cmd       (cmd)
    );

    // range memory, pointers, merge run and output register
    sitm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POS_WIDTH   (POS_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### dv/sitm_range_monitor.sv
`timescale 1ns / 100ps

module sitm_range_monitor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  sitm_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  sitm_pkg::rsp_t rsp,
    output int             error_count,
    output int             pending_count,
    output int             result_count,
    output int             full_count,
    output int             peak_count
);

    localparam int DEPTH = 64;

    logic [63:0]    ranges [DEPTH];
    int             n_ranges;
    sitm_pkg::rsp_t expected_rsp [$];
    sitm_pkg::rsp_t want;

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic sitm_pkg::rsp_t make_rsp(input logic [1:0] st,
                                                input sitm_pkg::pos_t f,
                                                input sitm_pkg::pos_t l,
                                                input logic fin);
        sitm_pkg::rsp_t r;
        r.status      = st;
        r.entry_count = sitm_pkg::count_t'(n_ranges);
        r.out_first   = f;
        r.out_last    = l;
        r.final_item  = fin;
        return r;
    endfunction

    // sorted insert, after any equal entries
    task automatic add_range(input sitm_pkg::pos_t f, input sitm_pkg::pos_t l);
        logic [63:0] key;
        int          p;
        key = {f, l};
        if (n_ranges >= DEPTH)
        begin
            full_count++;
            expected_rsp.push_back(make_rsp(sitm_pkg::ST_FULL, '0, '0, 1'b1));
            return;
        end
        p = n_ranges;
        while (p > 0 && ranges[p-1] > key)
        begin
            ranges[p] = ranges[p-1];
            p--;
        end
        ranges[p] = key;
        n_ranges++;
        if (n_ranges > peak_count)
            peak_count = n_ranges;
        expected_rsp.push_back(make_rsp(sitm_pkg::ST_OK, '0, '0, 1'b1));
    endtask

    // fold every overlapping range into the current run
    task automatic fold_overlaps();
        int             run;
        sitm_pkg::pos_t af, al, bf, bl;
        run = 0;
        for (int i = 1; i < n_ranges; i++)
        begin
            af = ranges[run][63:32];
            al = ranges[run][31:0];
            bf = ranges[i][63:32];
            bl = ranges[i][31:0];
            if (!(bl < af || bf > al))
                ranges[run] = {af, (bl > al) ? bl : al};
            else
            begin
                run++;
                ranges[run] = ranges[i];
            end
        end
        if (n_ranges > 0)
            n_ranges = run + 1;
        expected_rsp.push_back(make_rsp(sitm_pkg::ST_OK, '0, '0, 1'b1));
    endtask

    task automatic list_ranges();
        if (n_ranges == 0)
            expected_rsp.push_back(make_rsp(sitm_pkg::ST_EMPTY, '0, '0, 1'b1));
        for (int i = 0; i < n_ranges; i++)
            expected_rsp.push_back(make_rsp(sitm_pkg::ST_OK, ranges[i][63:32],
                                            ranges[i][31:0], i == n_ranges - 1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rsp.delete();
            n_ranges      = 0;
            error_count   = 0;
            pending_count = 0;
            result_count  = 0;
            full_count    = 0;
            peak_count    = 0;
        end
        else
        begin
            // check the response first: it can only belong to an earlier request
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    report_error($sformatf("unexpected response item %h", rsp));
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_error($sformatf("item %0d: status %0d, expected %0d",
                                               result_count, rsp.status, want.status));
                    if (rsp.entry_count !== want.entry_count)
                        report_error($sformatf("item %0d: entry_count %0d, expected %0d",
                                               result_count, rsp.entry_count,
                                               want.entry_count));
                    if (rsp.out_first !== want.out_first)
                        report_error($sformatf("item %0d: out_first %h, expected %h",
                                               result_count, rsp.out_first, want.out_first));
                    if (rsp.out_last !== want.out_last)
                        report_error($sformatf("item %0d: out_last %h, expected %h",
                                               result_count, rsp.out_last, want.out_last));
                    if (rsp.final_item !== want.final_item)
                        report_error($sformatf("item %0d: final_item %0b, expected %0b",
                                               result_count, rsp.final_item,
                                               want.final_item));
                end
                result_count++;
            end
            if (req_valid && req_ready)
            begin
                case (req.action)
                    sitm_pkg::ACT_INSERT: add_range(req.range_first, req.range_last);
                    sitm_pkg::ACT_MERGE:  fold_overlaps();
                    sitm_pkg::ACT_DUMP:   list_ranges();
                    default:
                        expected_rsp.push_back(make_rsp(sitm_pkg::ST_OK, '0, '0, 1'b1));
                endcase
            end
            pending_count = expected_rsp.size();
        end
    end

endmodule

### dv/sorted_interval_table_merge_test.sv
`timescale 1ns / 100ps

module sorted_interval_table_merge_test;

    // the block treats this action code as a no-op
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         ITEM_GOAL  = 300;
    localparam int         FILL_ROUND = 3;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           rsp_ready = 1'b0;
    sitm_pkg::req_t req       = '0;
    logic           req_ready;
    logic           rsp_valid;
    sitm_pkg::rsp_t rsp;

    int error_count, pending_count, result_count, full_count, peak_count;
    int n_sent, n_insert, n_merge, n_dump, n_other;

    // random idling on both channels; cleared for a long clean stretch
    bit stall_en = 1'b1;

    always #10 clk = ~clk;

    sorted_interval_table_merge u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sitm_range_monitor u_mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .full_count    (full_count),
        .peak_count    (peak_count)
    );

    // Receiver: stall about 31 percent of the time while idling is on,
    // otherwise take every response item as it comes.
    always @(negedge clk)
    begin
        rsp_ready = !stall_en || ($urandom_range(99) >= 31);
    end

    // Offer one request item at the falling edge and hold it until the block
    // takes it. Valid stays high across back-to-back items; a gap drops it.
    task automatic send(input logic [1:0] act, input sitm_pkg::pos_t f,
                        input sitm_pkg::pos_t l);
        while (stall_en && $urandom_range(99) < 31)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req.action      = act;
        req.range_first = f;
        req.range_last  = l;
        req_valid       = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
        n_sent++;
        case (act)
            sitm_pkg::ACT_INSERT: n_insert++;
            sitm_pkg::ACT_MERGE:  n_merge++;
            sitm_pkg::ACT_DUMP:   n_dump++;
            default:              n_other++;
        endcase
    endtask

    // Hold the sender off until every expected response item has come back.
    task automatic drain();
        req_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Pick a range: mostly clustered near base so that merges have work to
    // do, plus some fully random ranges, extreme endpoints and inverted ones.
    function automatic void pick_range(input sitm_pkg::pos_t base, input int unsigned span,
                                       output sitm_pkg::pos_t f, output sitm_pkg::pos_t l);
        int unsigned    roll;
        sitm_pkg::pos_t tmp;
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            f = $urandom;
            l = $urandom;
        end
        else if (roll < 14)
        begin
            f = $urandom_range(1) ? '1 : '0;
            l = $urandom_range(2) == 0 ? sitm_pkg::pos_t'($urandom)
                                       : ($urandom_range(1) ? '1 : '0);
        end
        else
        begin
            f = base + $urandom_range(span);
            l = f + $urandom_range(span / 4);
            if ($urandom_range(19) == 0)
            begin
                tmp = f;
                f   = l;
                l   = tmp;
            end
        end
    endfunction

    initial
    begin : stimulus
        sitm_pkg::pos_t base, f, l;
        int unsigned    span, burst, roll;
        int             round;

        // hold reset, then release it at a falling edge
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table cases first, then shared endpoints, touching
        // ranges, a duplicate, inverted ranges and the extremes of the
        // position field, then a range spanning everything to collapse it.
        send(sitm_pkg::ACT_DUMP,   $urandom, $urandom);
        send(sitm_pkg::ACT_MERGE,  $urandom, $urandom);
        send(ACT_UNUSED,           $urandom, $urandom);
        send(sitm_pkg::ACT_INSERT, 32'd10, 32'd20);
        send(sitm_pkg::ACT_INSERT, 32'd20, 32'd30);
        send(sitm_pkg::ACT_INSERT, 32'd31, 32'd40);
        send(sitm_pkg::ACT_INSERT, 32'd10, 32'd20);
        send(sitm_pkg::ACT_INSERT, 32'd50, 32'd5);
        send(sitm_pkg::ACT_INSERT, '0, '0);
        send(sitm_pkg::ACT_INSERT, '1, '1);
        send(sitm_pkg::ACT_INSERT, '1, '0);
        send(sitm_pkg::ACT_DUMP,   '0, '0);
        send(ACT_UNUSED,           '1, '1);
        send(sitm_pkg::ACT_MERGE,  '1, '1);
        send(sitm_pkg::ACT_DUMP,   $urandom, $urandom);
        send(sitm_pkg::ACT_INSERT, '0, '1);
        send(sitm_pkg::ACT_MERGE,  $urandom, $urandom);
        send(sitm_pkg::ACT_DUMP,   $urandom, $urandom);
        drain();

        // Random rounds: a burst of inserts around a random base with a few
        // stray operations mixed in, then usually a merge and a dump. One
        // round overfills the table; a few rounds run with no idling.
        for (round = 0; n_sent < ITEM_GOAL; round++)
        begin
            base     = $urandom;
            span     = $urandom_range(8, 400);
            stall_en = !(round >= 6 && round < 12);
            if (round == FILL_ROUND)
            begin
                for (int i = 0; i < 66; i++)
                begin
                    pick_range(base, span, f, l);
                    send(sitm_pkg::ACT_INSERT, f, l);
                end
                send(sitm_pkg::ACT_DUMP, $urandom, $urandom);
                drain();
                send(sitm_pkg::ACT_INSERT, '0, '1);
                send(sitm_pkg::ACT_MERGE, $urandom, $urandom);
                send(sitm_pkg::ACT_DUMP, $urandom, $urandom);
                drain();
            end
            else
            begin
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst; i++)
                begin
                    pick_range(base, span, f, l);
                    send(sitm_pkg::ACT_INSERT, f, l);
                    roll = $urandom_range(99);
                    if (roll < 6)
                        send(sitm_pkg::ACT_MERGE, $urandom, $urandom);
                    else if (roll < 11)
                        send(sitm_pkg::ACT_DUMP, $urandom, $urandom);
                    else if (roll < 14)
                        send(ACT_UNUSED, $urandom, $urandom);
                end
                // now and then sweep the table down to a single range
                if ($urandom_range(7) == 0)
                    send(sitm_pkg::ACT_INSERT, '0, '1);
                if ($urandom_range(9) != 0)
                    send(sitm_pkg::ACT_MERGE, $urandom, $urandom);
                send(sitm_pkg::ACT_DUMP, $urandom, $urandom);
                if ($urandom_range(5) == 0)
                    drain();
            end
        end

        // wait out the tail, then allow time for any stray response item
        stall_en = 1'b0;
        drain();
        repeat (150) @(negedge clk);

        $display("Sent %0d requests: %0d inserts, %0d merges, %0d dumps, %0d no-ops.",
                 n_sent, n_insert, n_merge, n_dump, n_other);
        $display("Checked %0d responses; table peaked at %0d ranges, %0d inserts refused.",
                 result_count, peak_count, full_count);
        if (error_count == 0)
            $display("sorted_interval_table_merge_test: clean");
        else
            $display("sorted_interval_table_merge_test: errors");
        $finish;
    end

    // watchdog: a correct run finishes far inside this
    initial
    begin
        #20_000_000;
        $display("Timed out with %0d response items outstanding.", pending_count);
        $display("sorted_interval_table_merge_test: errors");
        $finish;
    end

endmodule
